[src/tfm_pkg.sv]
// Package for the trigger fire mode controller: widths, register indexes,
// gesture mode codes and the state, configuration and result structs.
// No dependencies.
package tfm_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TIMEOUT_W  = 16;
    localparam int BURST_W    = 4;
    localparam int SPEED_W    = 12;
    localparam int SHOT_W     = 5;
    localparam int CMP_W      = (COUNT_BITS > TIMEOUT_W) ? COUNT_BITS : TIMEOUT_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_SHOTS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SINGLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_DOUBLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_HOLD   = 3'd4;

    // gesture / fire mode codes
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_DOUBLE = 2'd2;
    localparam logic [1:0] MODE_HOLD   = 2'd3;

    // register reset values
    localparam logic [TIMEOUT_W-1:0] RST_HOLD_TIMEOUT = 16'd3;
    localparam logic [BURST_W-1:0]   RST_BURST_SHOTS  = 4'd3;
    localparam logic [SPEED_W-1:0]   RST_SPEED_SINGLE = 12'd60;
    localparam logic [SPEED_W-1:0]   RST_SPEED_DOUBLE = 12'd120;
    localparam logic [SPEED_W-1:0]   RST_SPEED_HOLD   = 12'd1200;

    typedef struct packed {
        logic                  pending;
        logic [1:0]            mode;
        logic [COUNT_BITS-1:0] tick;
        logic [1:0]            prev_mode;
        logic [1:0]            fire_mode;
        logic                  fire_flag;
        logic [SHOT_W-1:0]     shot;
    } t_state;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] hold_timeout;
        logic [BURST_W-1:0]   burst_shots;
        logic [SPEED_W-1:0]   speed_single;
        logic [SPEED_W-1:0]   speed_double;
        logic [SPEED_W-1:0]   speed_hold;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         mode;
        logic               fire;
        logic [SPEED_W-1:0] speed;
    } t_result;

endpackage

[src/tfm_next.sv]
// Next-state logic for one tick: gesture classifier, fire sequencer and
// speed reference select. Purely combinational. Depends on tfm_pkg.
module tfm_next import tfm_pkg::*; (
    input  logic    i_trigger,
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    output t_state  o_state,
    output t_result o_result
);

    logic                 a, h, l, s, t;
    logic                 na, nh, nl;
    logic [1:0]           m;
    logic [COUNT_BITS-1:0] n_tick;
    logic [1:0]           n_fm;
    logic                 n_ff;
    logic [SHOT_W-1:0]    n_shot;
    logic [SHOT_W-1:0]    burst_ext;
    logic [SPEED_W-1:0]   speed;

    assign a = i_state.pending;
    assign h = i_state.mode[1];
    assign l = i_state.mode[0];
    assign s = i_trigger;
    assign t = (CMP_W'(i_state.tick) >= CMP_W'(i_cfg.hold_timeout));

    // gesture equations
    assign na = (a & ~h & ~s & ~t) | (~a & ~h & l & ~s & ~t);
    assign nh = (l & s & t) | (h & l & s) | (a & s & ~t);
    assign nl = (l & s) | (~a & ~h & s);
    assign m  = {nh, nl};

    // tick counter: clear in hold or idle, else saturating count
    always_comb begin
        if (m == MODE_HOLD || (!na && m == MODE_NONE)) begin
            n_tick = '0;
        end else if (!(&i_state.tick)) begin
            n_tick = i_state.tick + COUNT_BITS'(1);
        end else begin
            n_tick = i_state.tick;
        end
    end

    assign burst_ext = SHOT_W'(i_cfg.burst_shots);

    // fire sequencer
    always_comb begin
        n_fm = i_state.fire_mode;
        n_ff = i_state.fire_flag;
        unique case (i_state.fire_mode)
            MODE_NONE: begin
                n_fm = m;
                n_ff = (m != MODE_NONE);
            end
            MODE_SINGLE: begin
                if (i_state.fire_flag || m == MODE_SINGLE) begin
                    n_ff = 1'b0;
                end else if (m == MODE_DOUBLE || m == MODE_HOLD) begin
                    n_fm = m;
                    n_ff = 1'b1;
                end else begin
                    n_fm = MODE_NONE;
                    n_ff = 1'b0;
                end
            end
            MODE_DOUBLE: begin
                if (i_state.fire_flag) begin
                    n_ff = 1'b0;
                end else if (i_state.shot >= burst_ext) begin
                    n_fm = MODE_NONE;
                    n_ff = 1'b0;
                end else begin
                    n_ff = 1'b1;
                end
            end
            MODE_HOLD: begin
                n_fm = (i_state.fire_flag || m == MODE_HOLD) ? MODE_HOLD : MODE_NONE;
                n_ff = !i_state.fire_flag && m == MODE_HOLD;
            end
            default: begin
                n_fm = MODE_NONE;
                n_ff = 1'b0;
            end
        endcase
    end

    // burst shot counter; cleared once it passes the burst length
    always_comb begin
        n_shot = (i_state.shot > burst_ext) ? '0 : i_state.shot;
        if (n_fm == MODE_DOUBLE && n_ff) begin
            n_shot = n_shot + SHOT_W'(1);
        end
    end

    // speed reference only on a mode change
    always_comb begin
        speed = '0;
        if (m != i_state.prev_mode) begin
            case (m)
                MODE_SINGLE: speed = i_cfg.speed_single;
                MODE_DOUBLE: speed = i_cfg.speed_double;
                MODE_HOLD:   speed = i_cfg.speed_hold;
                default:     speed = '0;
            endcase
        end
    end

    assign o_state.pending   = na;
    assign o_state.mode      = m;
    assign o_state.tick      = n_tick;
    assign o_state.prev_mode = m;
    assign o_state.fire_mode = n_fm;
    assign o_state.fire_flag = n_ff;
    assign o_state.shot      = n_shot;

    assign o_result.mode  = m;
    assign o_result.fire  = n_ff;
    assign o_result.speed = speed;

endmodule

[src/trigger_fire_mode_controller_core.sv]
// Top level of the trigger fire mode controller: handshakes, configuration
// registers, input register, state and result register. Uses tfm_pkg, tfm_next.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_trigger) carries one trigger
//   sample per item, one item per control tick.
//   Output channel (o_out_valid / i_out_ready) returns one result item per
//   input item: o_gesture_mode, o_fire, o_speed_ref.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index /
//   i_cfg_data) writes hold_timeout (0), burst_shots (1), speed_single (2),
//   speed_double (3), speed_hold (4); other indexes are ignored. Writes are
//   always taken and should only be made while the block is idle.
// Path: an accepted item goes through the input register, then the state
//   update and result register.
// Throughput: one item per cycle, limited only by the output handshake.
// Stall: when the receiver holds off, the result register keeps its item;
//   the input register still fills once, then o_in_ready drops until the
//   result drains.
// Reset (synchronous, active low): state and valid flags clear, registers
//   return to their default values.
module trigger_fire_mode_controller_core import tfm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_trigger,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_gesture_mode,
    output logic                  o_fire,
    output logic [SPEED_W-1:0]    o_speed_ref
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_in_valid;
    logic    r_trigger;
    logic    r_out_valid;
    logic    adv;      // input register moves into state / result register
    logic    in_take;

    assign o_cfg_ready = 1'b1;

    // stage 2 advances when the result register is empty or being drained
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign in_take    = i_in_valid && o_in_ready;

    tfm_next u_next (
        .i_trigger (r_trigger),
        .i_state   (r_state),
        .i_cfg     (r_cfg),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_timeout <= RST_HOLD_TIMEOUT;
            r_cfg.burst_shots  <= RST_BURST_SHOTS;
            r_cfg.speed_single <= RST_SPEED_SINGLE;
            r_cfg.speed_double <= RST_SPEED_DOUBLE;
            r_cfg.speed_hold   <= RST_SPEED_HOLD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_HOLD_TIMEOUT: r_cfg.hold_timeout <= i_cfg_data[TIMEOUT_W-1:0];
                REG_BURST_SHOTS:  r_cfg.burst_shots  <= i_cfg_data[BURST_W-1:0];
                REG_SPEED_SINGLE: r_cfg.speed_single <= i_cfg_data[SPEED_W-1:0];
                REG_SPEED_DOUBLE: r_cfg.speed_double <= i_cfg_data[SPEED_W-1:0];
                REG_SPEED_HOLD:   r_cfg.speed_hold   <= i_cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_trigger <= i_trigger;
        end
    end

    // gesture and fire state, updated once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_gesture_mode = r_result.mode;
    assign o_fire         = r_result.fire;
    assign o_speed_ref    = r_result.speed;

endmodule

[tb/sv/tfm_gesture_board_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard for the trigger fire mode controller: per-tick gesture, fire and
// speed prediction plus in-order result checking. Depends on tfm_pkg.
package tfm_gesture_board_pkg;
    import tfm_pkg::*;

    class tfm_gesture_board;
        t_state  st;
        t_cfg    regs;
        t_result results_due[$];
        int      mismatches;
        int      results_seen;

        function new();
            st = '0;
            regs.hold_timeout = RST_HOLD_TIMEOUT;
            regs.burst_shots  = RST_BURST_SHOTS;
            regs.speed_single = RST_SPEED_SINGLE;
            regs.speed_double = RST_SPEED_DOUBLE;
            regs.speed_hold   = RST_SPEED_HOLD;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_HOLD_TIMEOUT: regs.hold_timeout = data[TIMEOUT_W-1:0];
                REG_BURST_SHOTS:  regs.burst_shots  = data[BURST_W-1:0];
                REG_SPEED_SINGLE: regs.speed_single = data[SPEED_W-1:0];
                REG_SPEED_DOUBLE: regs.speed_double = data[SPEED_W-1:0];
                REG_SPEED_HOLD:   regs.speed_hold   = data[SPEED_W-1:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return results_due.size();
        endfunction

        // One tick: gesture classifier, then fire sequencer on the new mode,
        // then speed reference on a mode change.
        function void note_trigger(logic trig);
            logic       a, h, l, t, na, nh, nl, f;
            logic [1:0] m;
            t_result    r;
            a = st.pending;
            h = st.mode[1];
            l = st.mode[0];
            t = (st.tick >= regs.hold_timeout);
            na = (a & ~h & ~trig & ~t) | (~a & ~h & l & ~trig & ~t);
            nh = (l & trig & t) | (h & l & trig) | (a & trig & ~t);
            nl = (l & trig) | (~a & ~h & trig);
            m = {nh, nl};
            st.pending = na;
            st.mode    = m;
            if (m == MODE_HOLD || (!na && m == MODE_NONE)) begin
                st.tick = '0;
            end else if (st.tick != '1) begin
                st.tick = st.tick + 1'b1;
            end

            case (st.fire_mode)
                MODE_NONE: begin
                    st.fire_mode = m;
                    st.fire_flag = (m != MODE_NONE);
                end
                MODE_SINGLE: begin
                    if (st.fire_flag || m == MODE_SINGLE) begin
                        st.fire_flag = 1'b0;
                    end else if (m == MODE_DOUBLE || m == MODE_HOLD) begin
                        st.fire_mode = m;
                        st.fire_flag = 1'b1;
                    end else begin
                        st.fire_mode = MODE_NONE;
                        st.fire_flag = 1'b0;
                    end
                end
                MODE_DOUBLE: begin
                    if (st.fire_flag) begin
                        st.fire_flag = 1'b0;
                    end else if (st.shot >= regs.burst_shots) begin
                        st.fire_mode = MODE_NONE;
                        st.fire_flag = 1'b0;
                    end else begin
                        st.fire_flag = 1'b1;
                    end
                end
                default: begin
                    f = st.fire_flag;
                    st.fire_mode = (f || m == MODE_HOLD) ? MODE_HOLD : MODE_NONE;
                    st.fire_flag = !f && m == MODE_HOLD;
                end
            endcase
            if (st.shot > regs.burst_shots) st.shot = '0;
            if (st.fire_mode == MODE_DOUBLE && st.fire_flag) st.shot = st.shot + 1'b1;

            r.mode = m;
            r.fire = st.fire_flag;
            if (m == st.prev_mode) begin
                r.speed = '0;
            end else begin
                case (m)
                    MODE_SINGLE: r.speed = regs.speed_single;
                    MODE_DOUBLE: r.speed = regs.speed_double;
                    MODE_HOLD:   r.speed = regs.speed_hold;
                    default:     r.speed = '0;
                endcase
            end
            st.prev_mode = m;
            results_due.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            results_seen++;
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d with nothing due: mode %0d fire %0b speed %0d",
                             results_seen, got.mode, got.fire, got.speed);
                return;
            end
            exp = results_due.pop_front();
            if (got.mode !== exp.mode || got.fire !== exp.fire || got.speed !== exp.speed) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected mode %0d fire %0b speed %0d, got mode %0d fire %0b speed %0d",
                             results_seen, exp.mode, exp.fire, exp.speed,
                             got.mode, got.fire, got.speed);
            end
        endfunction
    endclass

endpackage

[tb/sv/tb_trigger_fire_mode_controller_core.sv]
`timescale 1ns / 100ps
// Testbench top for trigger_fire_mode_controller_core: directed gestures, then
// random gesture phases under several register settings and idling schemes.
// Depends on tfm_pkg and tfm_gesture_board_pkg.
module tb_trigger_fire_mode_controller_core;
    import tfm_pkg::*;
    import tfm_gesture_board_pkg::*;

    // index with no register behind it; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int IDLE_LIMIT    = 2000;   // cycles without any handshake
    localparam int SETTLE_CYCLES = 4;      // quiet edges after the drain, before a register write
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 165;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_trigger   = 1'b0;
    logic                  i_out_ready = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [1:0]            o_gesture_mode;
    logic                  o_fire;
    logic [SPEED_W-1:0]    o_speed_ref;

    tfm_gesture_board gesture_board;
    t_result          seen;
    int               tx_idle_pct = 0;   // chance per cycle that the sender idles
    int               rx_idle_pct = 0;   // chance per cycle that the receiver stalls
    int               quiet_cycles = 0;
    int               items_sent = 0;
    int               hold_span;         // press/release lengths scale with this

    trigger_fire_mode_controller_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_trigger      (i_trigger),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_gesture_mode (o_gesture_mode),
        .o_fire         (o_fire),
        .o_speed_ref    (o_speed_ref)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: everything here reads values from just before the edge,
    // since the block's registers and our own drives only move in the NBA
    // region. The same block keeps the idle-cycle watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = {o_gesture_mode, o_fire, o_speed_ref};
            gesture_board.check_result(seen);
        end
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);

        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one trigger item, maybe after a short sender gap. Returns in the
    // time step of the accepting edge with valid still high, so a following
    // item keeps valid up without a drop.
    task automatic push_trigger(input logic trig);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_trigger  <= trig;
        do @(posedge i_clk); while (!o_in_ready);
        gesture_board.note_trigger(trig);
        items_sent++;
    endtask

    task automatic play_run(input logic trig, input int n);
        repeat (n) push_trigger(trig);
    endtask

    // Bits go out MSB first.
    task automatic play_bits(input logic [31:0] bits, input int n);
        for (int i = n - 1; i >= 0; i--) push_trigger(bits[i]);
    endtask

    // Stop sending and let every due result come back, then a few more
    // cycles so the block is quiet before any register write.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (gesture_board.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        gesture_board.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Directed: single and double gestures on reset values, a burst that
    // starts with the shot count already at burst_shots (one extra shot), a
    // burst_shots write that lands mid-burst below the shot count, a hold with
    // burst_shots of zero, and a hold_timeout of zero (timed out every tick).
    task automatic run_directed();
        play_bits(32'b1010_0000_0101, 12);
        wait_drained();
        write_reg(REG_BURST_SHOTS, 16'd0);
        play_bits(32'b00, 2);
        play_bits(32'b111110, 6);
        wait_drained();
        write_reg(REG_HOLD_TIMEOUT, 16'd0);
        play_bits(32'b1101, 4);
    endtask

    // Register set for one phase. Most phases keep hold_timeout small so the
    // timeouts are actually reached; a few pin every register at a fixed value, mostly an extreme.
    // Unused upper data bits are randomized to check they are dropped.
    task automatic load_phase_regs(input int p);
        logic [TIMEOUT_W-1:0] hold;
        logic [BURST_W-1:0]   burst;
        logic [SPEED_W-1:0]   sp_single, sp_double, sp_hold;
        hold  = ($urandom_range(3) == 0) ? 16'($urandom_range(7, 30))
                                         : 16'($urandom_range(1, 6));
        burst     = 4'($urandom_range(15));
        sp_single = 12'($urandom);
        sp_double = 12'($urandom);
        sp_hold   = 12'($urandom);
        case (p)
            1: begin
                hold = '0; burst = '1;
                sp_single = '1; sp_double = '1; sp_hold = '1;
            end
            5: begin
                hold = '1; burst = '0;
                sp_single = '0; sp_double = '0; sp_hold = '0;
            end
            9: begin
                hold = 16'd1; burst = 4'd1;
                sp_single = '1; sp_double = '0; sp_hold = '1;
            end
            default: ;
        endcase
        write_reg(REG_SPARE, 16'($urandom));
        write_reg(REG_HOLD_TIMEOUT, hold);
        write_reg(REG_BURST_SHOTS, {12'($urandom), burst});
        write_reg(REG_SPEED_SINGLE, {4'($urandom), sp_single});
        write_reg(REG_SPEED_DOUBLE, {4'($urandom), sp_double});
        write_reg(REG_SPEED_HOLD, {4'($urandom), sp_hold});
        if (hold > 40) hold_span = 40;
        else if (hold == 0) hold_span = 1;
        else hold_span = int'(hold);
    endtask

    // One gesture with random timing around the hold timeout: mostly clean
    // single, double and long-hold presses, some noise and broken doubles.
    task automatic play_gesture();
        int kind;
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2: begin
                play_run(1'b1, $urandom_range(1, hold_span));
                play_run(1'b0, $urandom_range(1, hold_span + 3));
            end
            3, 4, 5: begin
                play_run(1'b1, $urandom_range(1, hold_span));
                play_run(1'b0, $urandom_range(1, hold_span));
                play_run(1'b1, $urandom_range(1, 3));
                play_run(1'b0, $urandom_range(1, hold_span + 3));
            end
            6, 7: begin
                play_run(1'b1, hold_span + $urandom_range(0, 8));
                play_run(1'b0, $urandom_range(1, hold_span + 3));
            end
            8: begin
                repeat ($urandom_range(1, 8)) push_trigger(1'($urandom_range(1)));
            end
            default: begin
                // second press held on past the window
                play_run(1'b1, $urandom_range(1, hold_span));
                play_run(1'b0, $urandom_range(1, hold_span));
                play_run(1'b1, hold_span + $urandom_range(0, 4));
            end
        endcase
        // now and then the sender holds off until the block has emptied
        if ($urandom_range(49) == 0) wait_drained();
    endtask

    initial begin
        int target;
        gesture_board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // Idling schemes by thirds: sender light / receiver heavy, then the
        // reverse, then no idling at all.
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            tx_idle_pct = (p < PHASES / 3) ? 17 : (p < 2 * PHASES / 3) ? 83 : 0;
            rx_idle_pct = (p < PHASES / 3) ? 83 : (p < 2 * PHASES / 3) ? 17 : 0;
            load_phase_regs(p);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) play_gesture();
        end

        wait_drained();
        if (gesture_board.mismatches == 0 && gesture_board.outstanding() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
src/tfm_pkg.sv
src/tfm_next.sv
src/trigger_fire_mode_controller_core.sv
tb/sv/tfm_gesture_board_pkg.sv
tb/sv/tb_trigger_fire_mode_controller_core.sv
